@@ rtl/core/fp32_fused_multiply_add_macros.svh @@
// Assertion macros for the fp32 fused multiply-add core.
// No dependencies; included by files that carry concurrent checks.
`ifndef FP32_FUSED_MULTIPLY_ADD_MACROS_SVH
`define FP32_FUSED_MULTIPLY_ADD_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define FMAF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fmaf assertion failed");
// Condition must never be seen outside reset.
`define FMAF_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fmaf forbidden condition seen");
`else
`define FMAF_ASSERT(lbl, prop)
`define FMAF_NEVER(lbl, cond)
`endif
`endif

@@ rtl/core/fmaf_pkg.sv @@
// Shared types, constants and helper functions of the fp32 FMA core.
// No dependencies; used by fmaf_unpack and fp32_fused_multiply_add.
`timescale 1ns / 1ps
package fmaf_pkg;

    localparam logic [31:0] QNAN    = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX = 8'hFF;

    typedef struct packed {
        logic               sign;
        logic               zero;
        logic               inf;
        logic               nan;
        logic [23:0]        man;
        logic signed [10:0] q;
    } operand_t;

    typedef struct packed {
        logic        special;
        logic [31:0] val;
    } tag_t;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && v[i]) begin
                found = 1'b1;
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        logic       found;
        n = 7'd0;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && v[i]) begin
                found = 1'b1;
                n = 7'(63 - i);
            end
        end
        return n;
    endfunction

    // Right shift that folds every lost bit into bit 0.
    function automatic logic [63:0] shift_sticky(input logic [63:0] v,
                                                 input logic [10:0] amt);
        logic [63:0] mask;
        mask = ~({64{1'b1}} << amt[5:0]);
        if (amt >= 11'd64) begin
            return {63'd0, |v};
        end
        return (v >> amt[5:0]) | {63'd0, |(v & mask)};
    endfunction

endpackage

@@ rtl/core/fmaf_unpack.sv @@
// Operand decode: classify a binary32 word and normalize its significand.
// Depends on fmaf_pkg.
`timescale 1ns / 1ps
module fmaf_unpack
(
    input  logic [31:0]        word,
    output fmaf_pkg::operand_t opnd
);
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [4:0]  nlz;

    assign ex  = word[30:23];
    assign fr  = word[22:0];
    assign nlz = fmaf_pkg::lzc24({1'b0, fr});

    always_comb
    begin
        opnd.sign = word[31];
        opnd.zero = (word[30:0] == 31'd0);
        opnd.inf  = (ex == fmaf_pkg::EXP_MAX) && (fr == 23'd0);
        opnd.nan  = (ex == fmaf_pkg::EXP_MAX) && (fr != 23'd0);
        if (ex == 8'd0)
        begin
            // subnormal: shift up to the hidden bit, lower the exponent
            opnd.man = {1'b0, fr} << nlz;
            opnd.q   = -11'sd149 - $signed({6'd0, nlz});
        end
        else
        begin
            opnd.man = {1'b1, fr};
            opnd.q   = $signed({3'd0, ex}) - 11'sd150;
        end
    end
endmodule

@@ rtl/core/fp32_fused_multiply_add.sv @@
// Top level of the binary32 fused multiply-add pipeline.
// Depends on fmaf_pkg, fmaf_unpack and fp32_fused_multiply_add_macros.svh.
//
// Computes sum_out = mul_a * mul_b + addend with one rounding, round to
// nearest even, gradual underflow, overflow to signed infinity; every NaN
// result is the quiet NaN 0x7FC00000. No flags. Seven register stages:
// decode, 24x24 multiply, alignment, add/subtract, leading-zero count,
// rounding shift, increment and pack. The accepting edge loads the decode
// stage and out_valid rises once the word reaches the pack stage; one word
// is taken every cycle while in_stall is low. Each stage holds
// its own valid bit and advances whenever it is empty or the stage after it
// advances, so bubbles collapse and in_stall rises only when all seven
// stages hold a word and out_stall is high. Special operands (NaN, infinity,
// zero) are resolved in the decode stage and ride down the pipe as a tag.
`timescale 1ns / 1ps
`include "fp32_fused_multiply_add_macros.svh"
module fp32_fused_multiply_add
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] mul_a,
    input  logic [31:0] mul_b,
    input  logic [31:0] addend,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sum_out
);
    localparam int NSTG = 7;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    fmaf_pkg::operand_t ua, ub, uc;

    // stage 1: decode
    fmaf_pkg::tag_t     t1_reg, t1_next;
    logic               sp1_reg, sc1_reg, cz1_reg;
    logic [23:0]        ma1_reg, mb1_reg, mc1_reg;
    logic signed [10:0] qa1_reg, qb1_reg, qc1_reg;
    // stage 2: multiply
    fmaf_pkg::tag_t     t2_reg;
    logic               sp2_reg, sc2_reg, cz2_reg;
    logic [63:0]        pm2_reg, cm2_reg;
    logic signed [10:0] ep2_reg, ec2_reg;
    logic [47:0]        prod_next;
    // stage 3: align
    fmaf_pkg::tag_t     t3_reg;
    logic               sp3_reg, sc3_reg;
    logic [63:0]        pm3_reg, cm3_reg, pm3_next, cm3_next;
    logic signed [10:0] e3_reg, e3_next, d3;
    // stage 4: add
    fmaf_pkg::tag_t     t4_reg, t4_next;
    logic               sg4_reg, sg4_next;
    logic [63:0]        mag4_reg, mag4_next;
    logic signed [10:0] e4_reg;
    // stage 5: normalize count
    fmaf_pkg::tag_t     t5_reg;
    logic               sg5_reg;
    logic [63:0]        mag5_reg;
    logic signed [10:0] s5_reg, s5_next, lsb5_reg, lsb5_next, top5;
    logic [6:0]         lz5;
    // stage 6: round shift
    fmaf_pkg::tag_t     t6_reg;
    logic               sg6_reg, inc6_reg, inc6_next;
    logic [23:0]        q6_reg, q6_next;
    logic signed [10:0] lsb6_reg;
    logic [63:0]        shr6;
    logic [5:0]         sh6, shm6;
    // stage 7: pack
    logic [31:0]        sum_out_reg, sum_out_next;
    logic [24:0]        qr7;
    logic [23:0]        qn7;
    logic signed [10:0] lsb7, be7;

    fmaf_unpack u_unpack_a (.word(mul_a),  .opnd(ua));
    fmaf_unpack u_unpack_b (.word(mul_b),  .opnd(ub));
    fmaf_unpack u_unpack_c (.word(addend), .opnd(uc));

    // Advance a stage when it is empty or its successor advances.
    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || !out_stall;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NSTG-1];
    assign sum_out   = sum_out_reg;

    // Resolve special operands up front.
    always_comb
    begin
        logic sp;
        sp = ua.sign ^ ub.sign;
        t1_next.special = 1'b1;
        t1_next.val     = fmaf_pkg::QNAN;
        if (ua.nan || ub.nan || uc.nan)
        begin
            t1_next.val = fmaf_pkg::QNAN;
        end
        else if (ua.inf || ub.inf)
        begin
            if (ua.zero || ub.zero || (uc.inf && uc.sign != sp))
                t1_next.val = fmaf_pkg::QNAN;
            else
                t1_next.val = {sp, fmaf_pkg::EXP_MAX, 23'd0};
        end
        else if (uc.inf)
        begin
            t1_next.val = addend;
        end
        else if (ua.zero || ub.zero)
        begin
            t1_next.val = uc.zero ? {sp & uc.sign, 31'd0} : addend;
        end
        else
        begin
            t1_next.special = 1'b0;
        end
    end

    assign prod_next = ma1_reg * mb1_reg;

    // Align the smaller term; a zero addend keeps the product exponent.
    always_comb
    begin
        d3 = ep2_reg - ec2_reg;
        if (cz2_reg || d3 >= 11'sd0)
        begin
            pm3_next = pm2_reg;
            cm3_next = cz2_reg ? 64'd0 : fmaf_pkg::shift_sticky(cm2_reg, $unsigned(d3));
            e3_next  = ep2_reg;
        end
        else
        begin
            pm3_next = fmaf_pkg::shift_sticky(pm2_reg, $unsigned(-d3));
            cm3_next = cm2_reg;
            e3_next  = ec2_reg;
        end
    end

    // Add or subtract magnitudes; exact cancellation gives +0.
    always_comb
    begin
        t4_next   = t3_reg;
        mag4_next = pm3_reg + cm3_reg;
        sg4_next  = sp3_reg;
        if (sp3_reg != sc3_reg)
        begin
            if (pm3_reg == cm3_reg)
            begin
                mag4_next = 64'd0;
                if (!t3_reg.special)
                begin
                    t4_next.special = 1'b1;
                    t4_next.val     = 32'd0;
                end
            end
            else if (pm3_reg > cm3_reg)
            begin
                mag4_next = pm3_reg - cm3_reg;
            end
            else
            begin
                mag4_next = cm3_reg - pm3_reg;
                sg4_next  = sc3_reg;
            end
        end
    end

    // Find the result LSB position, clamped at the subnormal floor.
    always_comb
    begin
        lz5  = fmaf_pkg::lzc64(mag4_reg);
        top5 = $signed({4'd0, 7'd63 - lz5});
        lsb5_next = top5 + e4_reg - 11'sd23;
        if (lsb5_next < -11'sd149)
            lsb5_next = -11'sd149;
        s5_next = lsb5_next - e4_reg;
    end

    // Shift to 24 bits and decide the round-up.
    always_comb
    begin
        sh6  = s5_reg[5:0];
        shm6 = sh6 - 6'd1;
        shr6 = mag5_reg >> sh6;
        q6_next   = 24'd0;
        inc6_next = 1'b0;
        if (s5_reg <= 11'sd0)
        begin
            q6_next = mag5_reg[23:0] << 5'(-s5_reg);
        end
        else if (s5_reg >= 11'sd64)
        begin
            inc6_next = (s5_reg == 11'sd64) && mag5_reg[63] && (|mag5_reg[62:0]);
        end
        else
        begin
            q6_next   = shr6[23:0];
            inc6_next = mag5_reg[shm6] &&
                        ((|(mag5_reg & ~({64{1'b1}} << shm6))) || shr6[0]);
        end
    end

    // Increment, renormalize on carry, pack.
    always_comb
    begin
        qr7  = {1'b0, q6_reg} + {24'd0, inc6_reg};
        qn7  = qr7[23:0];
        lsb7 = lsb6_reg;
        if (qr7[24])
        begin
            qn7  = qr7[24:1];
            lsb7 = lsb6_reg + 11'sd1;
        end
        be7 = lsb7 + 11'sd150;
        if (t6_reg.special)
            sum_out_next = t6_reg.val;
        else if (!qn7[23])
            sum_out_next = {sg6_reg, 8'd0, qn7[22:0]};
        else if (be7 >= 11'sd255)
            sum_out_next = {sg6_reg, fmaf_pkg::EXP_MAX, 23'd0};
        else
            sum_out_next = {sg6_reg, be7[7:0], qn7[22:0]};
    end

    // Valid bits travel with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Payload: load on advance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t1_reg  <= t1_next;
            sp1_reg <= ua.sign ^ ub.sign;
            sc1_reg <= uc.sign;
            cz1_reg <= uc.zero;
            ma1_reg <= ua.man;
            mb1_reg <= ub.man;
            mc1_reg <= uc.man;
            qa1_reg <= ua.q;
            qb1_reg <= ub.q;
            qc1_reg <= uc.q;
        end
        if (en[1])
        begin
            t2_reg  <= t1_reg;
            sp2_reg <= sp1_reg;
            sc2_reg <= sc1_reg;
            cz2_reg <= cz1_reg;
            pm2_reg <= {1'b0, prod_next, 15'd0};
            cm2_reg <= {1'b0, mc1_reg, 39'd0};
            ep2_reg <= qa1_reg + qb1_reg - 11'sd15;
            ec2_reg <= qc1_reg - 11'sd39;
        end
        if (en[2])
        begin
            t3_reg  <= t2_reg;
            sp3_reg <= sp2_reg;
            sc3_reg <= sc2_reg;
            pm3_reg <= pm3_next;
            cm3_reg <= cm3_next;
            e3_reg  <= e3_next;
        end
        if (en[3])
        begin
            t4_reg   <= t4_next;
            sg4_reg  <= sg4_next;
            mag4_reg <= mag4_next;
            e4_reg   <= e3_reg;
        end
        if (en[4])
        begin
            t5_reg   <= t4_reg;
            sg5_reg  <= sg4_reg;
            mag5_reg <= mag4_reg;
            s5_reg   <= s5_next;
            lsb5_reg <= lsb5_next;
        end
        if (en[5])
        begin
            t6_reg   <= t5_reg;
            sg6_reg  <= sg5_reg;
            q6_reg   <= q6_next;
            inc6_reg <= inc6_next;
            lsb6_reg <= lsb5_reg;
        end
        if (en[6])
        begin
            sum_out_reg <= sum_out_next;
        end
    end

    // Back-pressure only when every stage is occupied.
    `FMAF_ASSERT(a_stall_full, in_stall |-> (&v_reg))
    // An accepted word lands in the decode stage.
    `FMAF_ASSERT(a_accept_lands, (in_valid && !in_stall) |=> v_reg[0])
    // Only the canonical NaN ever leaves the block.
    `FMAF_NEVER(a_nan_canon, out_valid && sum_out[30:23] == fmaf_pkg::EXP_MAX &&
                sum_out[22:0] != 23'd0 && sum_out != fmaf_pkg::QNAN)

endmodule

@@ verif/fp32_fused_multiply_add_checker.sv @@
// Checker for the binary32 fused multiply-add: watches both channels,
// predicts each sum from the accepted operands and compares in order.
// No dependencies beyond the block's port list.
`timescale 1ns / 1ps
module fp32_fused_multiply_add_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] mul_a,
    input  logic [31:0] mul_b,
    input  logic [31:0] addend,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] sum_out,
    output int          fail_count,
    output int          pending
);

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

    logic [31:0] sum_queue[$];

    function automatic bit nan_pat(input logic [31:0] x);
        return x[30:0] > INF_BITS[30:0];
    endfunction

    function automatic bit inf_pat(input logic [31:0] x);
        return x[30:0] == INF_BITS[30:0];
    endfunction

    function automatic bit zero_pat(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // Split a finite nonzero pattern into a 24-bit significand and lsb exponent.
    function automatic void split(input logic [31:0] x, output logic [63:0] m,
                                  output int q);
        m = {41'd0, x[22:0]};
        if (x[30:23] == 8'd0) begin
            q = -149;
            while (m < 64'h80_0000) begin
                m = m << 1;
                q--;
            end
        end
        else begin
            m = m | 64'h80_0000;
            q = int'(x[30:23]) - 150;
        end
    endfunction

    function automatic logic [63:0] sticky_shr(input logic [63:0] v, input int d);
        if (d <= 0) return v;
        if (d >= 64) return {63'd0, v != 0};
        return (v >> d) | {63'd0, (v & ((64'd1 << d) - 1)) != 0};
    endfunction

    // Round mag * 2^e (nonzero) once to binary32, nearest even.
    function automatic logic [31:0] round_bin32(input logic sgn, input logic [63:0] mag,
                                                input int e);
        int          top;
        int          lsb;
        int          s;
        int          biased;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        top = 63;
        while (!mag[top]) top--;
        lsb = top + e - 23;
        if (lsb < -149) lsb = -149;
        s = lsb - e;
        if (s <= 0) q = mag << (-s);
        else if (s >= 64) q = (s == 64 && mag > (64'd1 << 63)) ? 64'd1 : 64'd0;
        else
        begin
            rem  = mag & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            q    = mag >> s;
            if (rem > half || (rem == half && q[0])) q++;
        end
        if (q >= (64'd1 << 24)) begin
            q = q >> 1;
            lsb++;
        end
        if (q >= 64'h80_0000) begin
            biased = lsb + 150;
            if (biased >= 255) return {sgn, INF_BITS[30:0]};
            return {sgn, biased[7:0], q[22:0]};
        end
        return {sgn, q[30:0]};
    endfunction

    function automatic logic [31:0] predict_sum(input logic [31:0] a, input logic [31:0] b,
                                                input logic [31:0] c);
        logic        sp;
        logic        sc;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mc;
        logic [63:0] pm;
        logic [63:0] cm;
        int          qa;
        int          qb;
        int          qc;
        int          ep;
        int          ec;
        int          e;
        sp = a[31] ^ b[31];
        sc = c[31];
        if (nan_pat(a) || nan_pat(b) || nan_pat(c)) return CANON_NAN;
        if (inf_pat(a) || inf_pat(b)) begin
            if (zero_pat(a) || zero_pat(b)) return CANON_NAN;
            if (inf_pat(c) && sc != sp) return CANON_NAN;
            return {sp, INF_BITS[30:0]};
        end
        if (inf_pat(c)) return c;
        if (zero_pat(a) || zero_pat(b)) begin
            if (zero_pat(c)) return {sp & sc, 31'd0};
            return c;
        end
        split(a, ma, qa);
        split(b, mb, qb);
        pm = (ma * mb) << 15;
        ep = qa + qb - 15;
        if (zero_pat(c)) return round_bin32(sp, pm, ep);
        split(c, mc, qc);
        cm = mc << 39;
        ec = qc - 39;
        if (ep >= ec) begin
            cm = sticky_shr(cm, ep - ec);
            e = ep;
        end
        else begin
            pm = sticky_shr(pm, ec - ep);
            e = ec;
        end
        if (sp == sc) return round_bin32(sp, pm + cm, e);
        if (pm == cm) return 32'd0;
        if (pm > cm) return round_bin32(sp, pm - cm, e);
        return round_bin32(sc, cm - pm, e);
    endfunction

    assign pending = sum_queue.size();

    always @(posedge clk or negedge rst_n) begin
        logic [31:0] want;
        if (!rst_n) begin
            fail_count <= 0;
            sum_queue.delete();
        end
        else begin
            if (in_valid && !in_stall)
                sum_queue.push_back(predict_sum(mul_a, mul_b, addend));
            if (out_valid && !out_stall) begin
                if (sum_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected sum %h", sum_out);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = sum_queue.pop_front();
                    if (want !== sum_out) begin
                        if (fail_count < 10)
                            $display("sum_out mismatch: expected %h actual %h", want, sum_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ verif/fp32_fused_multiply_add_tb.sv @@
// Testbench top for fp32_fused_multiply_add: drives operand words, stalls
// the result side and gives the verdict. Depends on the block and the checker.
`timescale 1ns / 1ps
module fp32_fused_multiply_add_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] addend;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] sum_out;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          calm;          // no idling on either side while set

    // Directed operand triples: extremes and each special case.
    logic [31:0] directed_ops[$][3];

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    fp32_fused_multiply_add u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .addend   (addend),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sum_out  (sum_out)
    );

    fp32_fused_multiply_add_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .addend    (addend),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sum_out   (sum_out),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // Pick an operand from one of several classes so that specials,
    // subnormals and near-cancelling values show up often.
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'hFF;                            // inf or NaN
            1: v[30:0] = 31'd0;                             // zero
            2: v[30:23] = 8'h00;                            // subnormal
            3: v[30:23] = 8'(127 + $urandom_range(0, 6) - 3);
            4: v[30:23] = 8'($urandom_range(0, 1) ? $urandom_range(0, 30)
                                                  : $urandom_range(225, 254));
            default: ;
        endcase
        return v;
    endfunction

    // Random stall on the result side.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 30);
    end

    // Count cycles with no handshake on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("fp32_fused_multiply_add test failed");
            $finish;
        end
    end

    // Present one word and hold it until accepted; gap first at random.
    task automatic send_word(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c);
        if (!calm && $urandom_range(0, 99) < 30) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 50);
        end
        in_valid <= 1'b1;
        mul_a    <= a;
        mul_b    <= b;
        addend   <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial begin
        int wait_cycles;
        directed_ops = '{
            '{32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000},
            '{32'h7FC0_0001, 32'h3F80_0000, 32'h0000_0000},   // NaN operand
            '{32'h3F80_0000, 32'hFF80_0001, 32'h0000_0000},
            '{32'h0000_0000, 32'h3F80_0000, 32'h7FFF_FFFF},
            '{32'h7F80_0000, 32'h0000_0000, 32'h3F80_0000},   // inf times zero
            '{32'h7F80_0000, 32'h3F80_0000, 32'hFF80_0000},   // inf minus inf
            '{32'hFF80_0000, 32'h3F80_0000, 32'hFF80_0000},
            '{32'h7F80_0000, 32'hBF80_0000, 32'h3F80_0000},
            '{32'h3F80_0000, 32'h4000_0000, 32'hFF80_0000},   // infinite addend
            '{32'h0000_0000, 32'h3F80_0000, 32'hC040_0000},   // zero product
            '{32'h8000_0000, 32'h3F80_0000, 32'h8000_0000},   // both zeros negative
            '{32'h8000_0000, 32'h3F80_0000, 32'h0000_0000},
            '{32'h3F80_0000, 32'h4000_0000, 32'hC000_0000},   // exact cancellation
            '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0000},   // overflow
            '{32'hFF7F_FFFF, 32'h4000_0000, 32'h7F7F_FFFF},
            '{32'h0000_0001, 32'h0000_0001, 32'h0000_0000},   // underflow to zero
            '{32'h0000_0001, 32'h3F00_0000, 32'h0000_0000},   // tie to even
            '{32'h007F_FFFF, 32'h3F80_0000, 32'h0000_0001},
            '{32'h0080_0000, 32'h3F00_0000, 32'h8000_0000},
            '{32'h3F80_0001, 32'h3F80_0001, 32'hBF80_0002},
            '{32'h4B7F_FFFF, 32'h3F80_0000, 32'h3F00_0000},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
        };
        calm      = 1'b0;
        in_valid  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        addend    = '0;
        rst_n     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_ops[i])
            send_word(directed_ops[i][0], directed_ops[i][1], directed_ops[i][2]);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // Hold full rate on both sides for one long stretch.
            calm = (n >= 400 && n < 600);
            if ($urandom_range(0, 3) == 0)
                send_word($urandom(), $urandom(), $urandom());
            else
                send_word(pick_operand(), pick_operand(), pick_operand());
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Drain, then allow the pipeline depth to settle.
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("fp32_fused_multiply_add test passed");
        else
            $display("fp32_fused_multiply_add test failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/fmaf_pkg.sv
rtl/core/fmaf_unpack.sv
rtl/core/fp32_fused_multiply_add.sv
verif/fp32_fused_multiply_add_checker.sv
verif/fp32_fused_multiply_add_tb.sv
